>>> rtl/multichannel_software_pwm_unit_defines.svh
// assertion macros used by the channel walk sequencer of the pwm unit
`ifndef MULTICHANNEL_SOFTWARE_PWM_UNIT_DEFINES_SVH
`define MULTICHANNEL_SOFTWARE_PWM_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk with reset masking
`define SWPWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWPWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/swpwm_pkg.sv
// shared types and codes of the pwm unit
`timescale 1ns / 1ps
package swpwm_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BIND    = 2'd1,
    OP_RETUNE  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [4:0]  pin;
    logic [15:0] count;
    logic [15:0] period;
    logic [15:0] term;
    logic [31:0] remaining;
  } chan_rec_t;

  typedef struct packed {
    logic [31:0] pin_levels;
    logic        matched;
  } res_t;

endpackage

>>> rtl/swpwm_chan_ram.sv
// channel table memory, one write port and one registered read port
`timescale 1ns / 1ps
module swpwm_chan_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output swpwm_pkg::chan_rec_t rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  swpwm_pkg::chan_rec_t wr_data
);
  import swpwm_pkg::*;

  chan_rec_t mem [DEPTH];
  chan_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/swpwm_ctrl.sv
// channel walk sequencer: flags, pin levels and read-modify-write of the table
`timescale 1ns / 1ps
module swpwm_ctrl #(
  parameter int CHANNELS = 8,
  parameter int PINS     = 32,
  parameter int AW       = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_operation,
  input  logic [4:0]           in_pin,
  input  logic [15:0]          in_period,
  input  logic [15:0]          in_term,
  input  logic [31:0]          in_length,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  swpwm_pkg::chan_rec_t rd_rec,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output swpwm_pkg::chan_rec_t wr_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output swpwm_pkg::res_t      res
);
  import swpwm_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

  st_t               state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic [CHANNELS-1:0] active_r, active_nxt;
  logic [CHANNELS-1:0] bound_r, bound_nxt;
  logic [PINS-1:0]   lvl_r, lvl_nxt;
  op_t               op_r;
  logic [4:0]        pin_r;
  logic [15:0]       period_r;
  logic [15:0]       term_r;
  logic [31:0]       length_r;
  logic              pin_in_r;
  logic [63:0]       lvl_wide;

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      found_r  <= 1'b0;
      active_r <= '0;
      bound_r  <= '0;
      lvl_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      found_r  <= found_nxt;
      active_r <= active_nxt;
      bound_r  <= bound_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  // operation fields held for the whole walk
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r     <= op_t'(in_operation);
      pin_r    <= in_pin;
      period_r <= in_period;
      term_r   <= in_term;
      length_r <= in_length;
      pin_in_r <= (int'(in_pin) < PINS);
    end
  end

  always_comb begin
    chan_rec_t       rec;
    logic            pin_hit;
    logic [15:0]     cnt_inc;
    logic [PINS-1:0] mask;
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    active_nxt = active_r;
    bound_nxt  = bound_r;
    lvl_nxt    = lvl_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_rec;
    res_valid  = 1'b0;
    rec        = rd_rec;
    pin_hit    = bound_r[idx_r] && (rd_rec.pin == pin_r);
    cnt_inc    = rd_rec.count + 16'd1;
    mask       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (op_r)
          OP_TICK: begin
            if (active_r[idx_r]) begin
              // pins at or above the vector width shift out to nothing
              mask = PINS'(1) << rd_rec.pin;
              if (rd_rec.count == rd_rec.term) begin
                lvl_nxt = lvl_r & ~mask;
              end else if (rd_rec.count == 16'd0) begin
                lvl_nxt = lvl_r | mask;
              end
              if (rd_rec.remaining != 32'd0) begin
                rec.remaining = rd_rec.remaining - 32'd1;
                if (rec.remaining == 32'd0) begin
                  active_nxt[idx_r] = 1'b0;
                end
              end
              rec.count = (cnt_inc >= rd_rec.period) ? 16'd0 : cnt_inc;
              wr_en     = 1'b1;
              wr_data   = rec;
            end
          end
          OP_BIND: begin
            if (!found_r && pin_in_r && (!active_r[idx_r] || pin_hit)) begin
              rec.pin           = pin_r;
              rec.count         = 16'd0;
              rec.period        = period_r;
              rec.term          = term_r;
              rec.remaining     = length_r;
              wr_en             = 1'b1;
              wr_data           = rec;
              bound_nxt[idx_r]  = 1'b1;
              active_nxt[idx_r] = 1'b1;
              found_nxt         = 1'b1;
            end
          end
          OP_RETUNE: begin
            if (!found_r && pin_in_r && pin_hit) begin
              rec.period        = period_r;
              rec.term          = term_r;
              rec.remaining     = length_r;
              wr_en             = 1'b1;
              wr_data           = rec;
              active_nxt[idx_r] = 1'b1;
              found_nxt         = 1'b1;
            end
          end
          OP_RELEASE: begin
            if (!found_r && pin_in_r && active_r[idx_r] && pin_hit) begin
              mask              = PINS'(1) << pin_r;
              lvl_nxt           = lvl_r & ~mask;
              bound_nxt[idx_r]  = 1'b0;
              active_nxt[idx_r] = 1'b0;
              found_nxt         = 1'b1;
            end
          end
          default: ;
        endcase
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign lvl_wide       = 64'(lvl_r);
  assign res.pin_levels = lvl_wide[31:0];
  assign res.matched    = (op_r == OP_TICK) || found_r;

`include "multichannel_software_pwm_unit_defines.svh"

  `SWPWM_ASSERT_NOW(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr,
                    "table read and write hit the same channel")
  `SWPWM_ASSERT_NOW(a_active_bound, 1'b1, (active_r & ~bound_r) == '0,
                    "active channel without a pin")
  `SWPWM_ASSERT_NEXT(a_tick_keeps_bind, state_r == ST_RUN && op_r == OP_TICK,
                     bound_r == $past(bound_r), "tick changed a pin binding")

endmodule

>>> rtl/multichannel_software_pwm_unit.sv
// top level of the multichannel software pwm unit
`timescale 1ns / 1ps
// input channel (in_valid / in_stall): one operation per transfer, a tick,
// a bind, a retune or a release of a pin. output channel (out_valid /
// out_stall): one result per operation, the pin-level vector and a matched
// flag, delivered in operation order.
//
// the channel table (pin, count, period, term, remaining) sits in a
// single-port-write, registered-read memory; active and bound flags and the
// pin levels are flops. every operation walks all CHANNELS entries, one
// read-modify-write per cycle, in index order.
//
// the result is loaded into the output register once the walk has passed
// the last entry and the slot is free. a new operation is taken only back
// in ST_IDLE, after the result of the last one has gone to that register.
//
// the output register decouples the sides: while a result waits under
// out_stall the next operation is already taken and walked; only a second
// finished result waits for the slot.
//
// reset (synchronous, rst_n low) clears the flags, the pin levels and the
// output valid; table entries are only used once a bind has written them
module multichannel_software_pwm_unit #(
  parameter int CHANNELS = 8,
  parameter int PINS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_pin,
  input  logic [15:0] in_period,
  input  logic [15:0] in_term,
  input  logic [31:0] in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pin_levels,
  output logic        out_matched
);
  import swpwm_pkg::*;

  // table address width, at least one bit for a single channel
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  chan_rec_t     rd_rec;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  chan_rec_t     wr_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_levels_r;
  logic          out_matched_r;

  swpwm_chan_ram #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  swpwm_ctrl #(
    .CHANNELS (CHANNELS),
    .PINS     (PINS),
    .AW       (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_pin       (in_pin),
    .in_period    (in_period),
    .in_term      (in_term),
    .in_length    (in_length),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_rec       (rd_rec),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // slot is free when empty or when its result leaves this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only loads on a new result, so it holds while stalled
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_levels_r  <= res.pin_levels;
      out_matched_r <= res.matched;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_levels_r;
  assign out_matched    = out_matched_r;

endmodule
